[rtl/tea_pkg.sv]
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and round functions for the TEA cipher unit.
// ----------------------------------------------------------------------------
package tea_pkg;

  localparam int ROUND_COUNT = 32;
  localparam int STEP_COUNT  = 2 * ROUND_COUNT;   // one cell per half-round
  localparam int WORD_W      = 32;
  localparam int KEY_WORDS   = 4;
  localparam int KEY_IDX_W   = $clog2(KEY_WORDS);

  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

  // Key register indexes
  localparam logic [KEY_IDX_W-1:0] KEY_IDX_0 = KEY_IDX_W'(0);
  localparam logic [KEY_IDX_W-1:0] KEY_IDX_1 = KEY_IDX_W'(1);
  localparam logic [KEY_IDX_W-1:0] KEY_IDX_2 = KEY_IDX_W'(2);
  localparam logic [KEY_IDX_W-1:0] KEY_IDX_3 = KEY_IDX_W'(3);

  // Operation selector
  localparam logic FUNC_ENCRYPT = 1'b0;
  localparam logic FUNC_DECRYPT = 1'b1;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

  // One block travelling down the cell chain
  typedef struct packed {
    logic              func;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
  } blk_t;

  // Round mixing function of one half-round
  function automatic logic [WORD_W-1:0] mix_half(input logic [WORD_W-1:0] h,
                                                 input logic [WORD_W-1:0] sum,
                                                 input logic [WORD_W-1:0] kl,
                                                 input logic [WORD_W-1:0] kr);
    return ((h << 4) + kl) ^ (h + sum) ^ ((h >> 5) + kr);
  endfunction

  // Running sum seen by half-round step s when encrypting
  function automatic logic [WORD_W-1:0] enc_sum(input int s);
    logic [63:0] prod;
    prod = 64'(TEA_DELTA) * 64'(s / 2 + 1);
    return prod[WORD_W-1:0];
  endfunction

  // Running sum seen by half-round step s when decrypting
  function automatic logic [WORD_W-1:0] dec_sum(input int s);
    logic [63:0] prod;
    prod = 64'(TEA_DELTA) * 64'(ROUND_COUNT - s / 2);
    return prod[WORD_W-1:0];
  endfunction

endpackage

[rtl/tea_key_regs.sv]
// ----------------------------------------------------------------------------
// tea_key_regs
// Holds the four 32-bit key words written through the configuration port.
// ----------------------------------------------------------------------------
module tea_key_regs
  import tea_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [KEY_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  output key_t                 key
);

  // Key word write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        KEY_IDX_0: key[0] <= cfg_data;
        KEY_IDX_1: key[1] <= cfg_data;
        KEY_IDX_2: key[2] <= cfg_data;
        KEY_IDX_3: key[3] <= cfg_data;
        default:   key    <= key;
      endcase
    end
  end

endmodule

[rtl/tea_cell.sv]
// ----------------------------------------------------------------------------
// tea_cell
// One half-round of TEA: updates one half of the block from the other and
// hands the block on to the next cell.
// ----------------------------------------------------------------------------
module tea_cell
  import tea_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  blk_t              in_blk,
  input  key_t              key,
  input  logic              odd_step,   // second half-round of a round
  input  logic [WORD_W-1:0] sum_enc,
  input  logic [WORD_W-1:0] sum_dec,
  output logic              out_valid,
  output blk_t              out_blk
);

  logic              upd_y;
  logic [WORD_W-1:0] src;
  logic [WORD_W-1:0] dst;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] kl;
  logic [WORD_W-1:0] kr;
  logic [WORD_W-1:0] mix;
  logic [WORD_W-1:0] dst_next;
  blk_t              blk_next;

  // Encrypt: y on even steps, z on odd. Decrypt runs the other way round.
  always_comb begin
    upd_y    = (in_blk.func == odd_step);
    src      = upd_y ? in_blk.z : in_blk.y;
    dst      = upd_y ? in_blk.y : in_blk.z;
    kl       = upd_y ? key[0] : key[2];
    kr       = upd_y ? key[1] : key[3];
    sum      = (in_blk.func == FUNC_DECRYPT) ? sum_dec : sum_enc;
    mix      = mix_half(src, sum, kl, kr);
    dst_next = (in_blk.func == FUNC_DECRYPT) ? dst - mix : dst + mix;
    blk_next = in_blk;
    if (upd_y) begin
      blk_next.y = dst_next;
    end else begin
      blk_next.z = dst_next;
    end
  end

  // Stage registers: valid is control, block is payload
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_blk <= blk_next;
  end

endmodule

[rtl/tea_block_cipher_unit.sv]
// ----------------------------------------------------------------------------
// tea_block_cipher_unit
// TEA encrypt/decrypt of 64-bit blocks under a 128-bit key, built as a chain
// of half-round cells.
//
//   channel  direction  transfer when        fields
//   -------  ---------  -------------------  ----------------------------
//   input    in         start & !busy        func, word_y, word_z
//   result   out        done (one cycle)     out_y, out_z
//   config   in         cfg_we               cfg_index, cfg_data
//
// One block is taken in every cycle; busy is never raised.
// There is one register stage per half-round cell, the last stage driving
// the result ports.
// rst (synchronous) clears the key words and all stage valid flags.
// The receiver cannot stall: done pulses for exactly one cycle per block.
// ----------------------------------------------------------------------------
module tea_block_cipher_unit
  import tea_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 func,
  input  logic [WORD_W-1:0]    word_y,
  input  logic [WORD_W-1:0]    word_z,
  output logic                 done,
  output logic [WORD_W-1:0]    out_y,
  output logic [WORD_W-1:0]    out_z,
  input  logic                 cfg_we,
  input  logic [KEY_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  key_t key;
  logic [STEP_COUNT:0] vld;
  blk_t                blk [STEP_COUNT+1];

  // Key storage
  tea_key_regs u_keys (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  // Chain head
  assign busy      = 1'b0;
  assign vld[0]    = start & ~busy;
  assign blk[0]    = '{func: func, y: word_y, z: word_z};

  // Half-round cells
  for (genvar s = 0; s < STEP_COUNT; s++) begin : g_cell
    localparam logic [WORD_W-1:0] SumEnc = enc_sum(s);
    localparam logic [WORD_W-1:0] SumDec = dec_sum(s);
    localparam logic              OddStep = (s % 2) == 1;

    tea_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[s]),
      .in_blk    (blk[s]),
      .key       (key),
      .odd_step  (OddStep),
      .sum_enc   (SumEnc),
      .sum_dec   (SumDec),
      .out_valid (vld[s+1]),
      .out_blk   (blk[s+1])
    );
  end

  // Result from the last cell
  assign done  = vld[STEP_COUNT];
  assign out_y = blk[STEP_COUNT].y;
  assign out_z = blk[STEP_COUNT].z;

endmodule
